@@ rtl/rea_pkg.sv @@
// Shared types, constants and saturating arithmetic for the radio energy accountant.
// No dependencies; imported by every module of the block.
package rea_pkg;

  // Field and register widths
  localparam int unsigned TIME_WIDTH_DEF = 48;
  localparam int unsigned ENERGY_WIDTH   = 64;
  localparam int unsigned EMAG_W         = ENERGY_WIDTH - 1;
  localparam int unsigned MODE_W         = 3;
  localparam int unsigned DUR_W          = 32;
  localparam int unsigned CUR_W          = 26;
  localparam int unsigned SUP_W          = 16;
  localparam int unsigned US16_W         = 16;
  localparam int unsigned CS_W           = CUR_W + SUP_W;
  localparam int unsigned CFG_IDX_W      = 3;
  localparam int unsigned CFG_DATA_W     = EMAG_W;
  localparam int unsigned OUT_FIELDS_W   = 3 * ENERGY_WIDTH + 4 * EMAG_W + 1;
  localparam int unsigned OUT_TDATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Energy is current * time * supply / FJ_DIVISOR
  localparam int unsigned FJ_DIVISOR     = 1000;

  // Register reset values
  localparam logic [SUP_W-1:0]  SUPPLY_RST     = SUP_W'(3000);
  localparam logic [CUR_W-1:0]  TX_CUR_RST     = CUR_W'(17400000);
  localparam logic [CUR_W-1:0]  RX_CUR_RST     = CUR_W'(19700000);
  localparam logic [CUR_W-1:0]  IDLE_CUR_RST   = CUR_W'(20000);
  localparam logic [CUR_W-1:0]  SLEEP_CUR_RST  = CUR_W'(1000);
  localparam logic [EMAG_W-1:0] INIT_ENERGY_RST = '0;
  localparam logic [US16_W-1:0] CCA_TIME_RST   = US16_W'(128);
  localparam logic [US16_W-1:0] MIN_GAP_RST    = US16_W'(70);

  typedef logic signed [ENERGY_WIDTH-1:0] energy_t;

  localparam energy_t ENERGY_MAX_C = {1'b0, {EMAG_W{1'b1}}};
  localparam energy_t ENERGY_MIN_C = {1'b1, {EMAG_W{1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SUPPLY_MV   = 3'd0,
    CFG_TX_CUR      = 3'd1,
    CFG_RX_CUR      = 3'd2,
    CFG_IDLE_CUR    = 3'd3,
    CFG_SLEEP_CUR   = 3'd4,
    CFG_INIT_ENERGY = 3'd5,
    CFG_CCA_TIME    = 3'd6,
    CFG_MIN_GAP     = 3'd7
  } cfg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_TX          = 3'd0,
    MODE_RX          = 3'd1,
    MODE_CCA         = 3'd2,
    MODE_SLEEP_START = 3'd3,
    MODE_SLEEP_END   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    CUR_TX,
    CUR_RX,
    CUR_IDLE,
    CUR_SLEEP
  } cur_sel_e;

  typedef enum logic [1:0] {
    TSEL_DUR,
    TSEL_SPAN,
    TSEL_CCA
  } time_sel_e;

  typedef enum logic [2:0] {
    CAT_TX,
    CAT_RX,
    CAT_CCA,
    CAT_IDLE,
    CAT_SLEEP
  } cat_e;

  typedef enum logic [2:0] {
    EU_IDLE,
    EU_CS,
    EU_MUL,
    EU_DIV,
    EU_DONE
  } eu_state_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_DIFF,
    SQ_SPAN,
    SQ_REQ,
    SQ_WAIT,
    SQ_CONSUME,
    SQ_OUT
  } sq_state_e;

  // One energy charge of an event
  typedef struct packed {
    logic      valid;
    cur_sel_e  cur;
    time_sel_e tsel;
    cat_e      cat;
    logic      sub;
    logic      last;
  } job_t;

  // Sequencer to ledger commands
  typedef struct packed {
    logic clear;
    logic apply;
    cat_e cat;
    logic sub;
    logic consume;
  } ledger_cmd_t;

  // Ledger totals seen by the output stage
  typedef struct packed {
    energy_t remaining;
    energy_t event_fj;
    energy_t tx;
    energy_t rx;
    energy_t cca;
    energy_t idle;
    energy_t sleep;
  } ledger_totals_t;

  // Signed add or subtract, clamped to the energy range
  function automatic energy_t sat_addsub(energy_t a, energy_t b, logic sub);
    logic [ENERGY_WIDTH:0] s;
    energy_t               r;
    if (sub) begin
      s = {a[ENERGY_WIDTH-1], a} - {b[ENERGY_WIDTH-1], b};
    end else begin
      s = {a[ENERGY_WIDTH-1], a} + {b[ENERGY_WIDTH-1], b};
    end
    if (s[ENERGY_WIDTH] != s[ENERGY_WIDTH-1]) begin
      r = s[ENERGY_WIDTH] ? ENERGY_MIN_C : ENERGY_MAX_C;
    end else begin
      r = s[ENERGY_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

@@ rtl/rea_energy_unit.sv @@
// Iterative energy unit: floor(current * supply * time / 1000), clamped to 63 bits.
// One shared multiplier forms current*supply, then the time product chunk by chunk;
// a radix-16 long division by 1000 follows. Depends on rea_pkg.
module rea_energy_unit #(
  parameter int unsigned TIME_WIDTH = rea_pkg::TIME_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rea_pkg::CUR_W-1:0]  current_i,
  input  logic [rea_pkg::SUP_W-1:0]  supply_i,
  input  logic [TIME_WIDTH-1:0]      time_i,
  output logic                       done_o,
  output logic [rea_pkg::EMAG_W-1:0] energy_o
);
  import rea_pkg::*;

  localparam int unsigned NCH   = (TIME_WIDTH + SUP_W - 1) / SUP_W;
  localparam int unsigned TPAD  = NCH * SUP_W;
  localparam int unsigned PW    = CS_W + TPAD;
  localparam int unsigned DIG_W = 4;
  localparam int unsigned PDW   = ((PW + DIG_W - 1) / DIG_W) * DIG_W;
  localparam int unsigned ND    = PDW / DIG_W;
  localparam int unsigned CNT_W = $clog2(ND);
  localparam int unsigned MP_W  = CS_W + SUP_W;
  localparam int unsigned REM_W = $clog2(FJ_DIVISOR);
  localparam int unsigned V_W   = REM_W + DIG_W;

  eu_state_e          state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CUR_W-1:0]   cur_q;
  logic [CS_W-1:0]    cs_q;
  logic [TPAD-1:0]    t_q;
  logic [PDW-1:0]     prod_q;
  logic [REM_W-1:0]   rem_q;
  logic [EMAG_W-1:0]  quot_q;
  logic               sat_q;

  logic [CS_W-1:0]    mul_a;
  logic [SUP_W-1:0]   mul_b;
  logic [MP_W-1:0]    mul_p;
  logic [V_W-1:0]     div_v;
  logic [DIG_W-1:0]   digit;
  logic [REM_W-1:0]   rem_n;

  // Shared multiplier: current*supply first, then one time chunk per cycle
  always_comb begin
    mul_a = cs_q;
    mul_b = t_q[TPAD-1 -: SUP_W];
    if (state_q == EU_CS) begin
      mul_a = CS_W'(cur_q);
      mul_b = supply_i;
    end
    mul_p = MP_W'(mul_a) * MP_W'(mul_b);
  end

  // One quotient digit by 1000 per cycle
  always_comb begin
    div_v = {rem_q, prod_q[PDW-1 -: DIG_W]};
    digit = '0;
    for (int k = 1; k < (1 << DIG_W); k++) begin
      if (div_v >= V_W'(k * FJ_DIVISOR)) begin
        digit = digit + DIG_W'(1);
      end
    end
    rem_n = REM_W'(div_v - V_W'(digit) * V_W'(FJ_DIVISOR));
  end

  // Sequence the phases
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      EU_IDLE: begin
        if (start_i) begin
          state_d = EU_CS;
        end
      end
      EU_CS: begin
        state_d = EU_MUL;
        cnt_d   = '0;
      end
      EU_MUL: begin
        if (cnt_q == CNT_W'(NCH - 1)) begin
          state_d = EU_DIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      EU_DIV: begin
        if (cnt_q == CNT_W'(ND - 1)) begin
          state_d = EU_DONE;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      EU_DONE: begin
        state_d = EU_IDLE;
      end
      default: begin
        state_d = EU_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EU_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      EU_IDLE: begin
        if (start_i) begin
          cur_q  <= current_i;
          t_q    <= TPAD'(time_i);
          prod_q <= '0;
          rem_q  <= '0;
          quot_q <= '0;
          sat_q  <= 1'b0;
        end
      end
      EU_CS: begin
        cs_q <= mul_p[CS_W-1:0];
      end
      EU_MUL: begin
        prod_q <= (prod_q << SUP_W) + PDW'(mul_p);
        t_q    <= t_q << SUP_W;
      end
      EU_DIV: begin
        prod_q <= prod_q << DIG_W;
        rem_q  <= rem_n;
        quot_q <= {quot_q[EMAG_W-DIG_W-1:0], digit};
        sat_q  <= sat_q | (|quot_q[EMAG_W-1 -: DIG_W]);
      end
      default: begin
      end
    endcase
  end

  assign done_o   = (state_q == EU_DONE);
  assign energy_o = sat_q ? {EMAG_W{1'b1}} : quot_q;

endmodule

@@ rtl/rea_ledger.sv @@
// Energy ledger: per-category totals, event energy and total consumption, all saturating.
// Driven by commands from the sequencer. Depends on rea_pkg.
module rea_ledger (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rea_pkg::ledger_cmd_t       cmd_i,
  input  logic [rea_pkg::EMAG_W-1:0] energy_i,
  input  logic [rea_pkg::EMAG_W-1:0] init_i,
  output rea_pkg::ledger_totals_t    totals_o
);
  import rea_pkg::*;

  energy_t tx_q, rx_q, cca_q, idle_q, sleep_q, cons_q, ev_q;
  energy_t e_ext, acc_sel, acc_new, ev_new, cons_new;

  // Select the category and form the clamped updates
  always_comb begin
    e_ext = {1'b0, energy_i};
    unique case (cmd_i.cat)
      CAT_TX:    acc_sel = tx_q;
      CAT_RX:    acc_sel = rx_q;
      CAT_CCA:   acc_sel = cca_q;
      CAT_IDLE:  acc_sel = idle_q;
      CAT_SLEEP: acc_sel = sleep_q;
      default:   acc_sel = '0;
    endcase
    acc_new  = sat_addsub(acc_sel, e_ext, cmd_i.sub);
    ev_new   = sat_addsub(ev_q, e_ext, cmd_i.sub);
    cons_new = sat_addsub(cons_q, ev_q, 1'b0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q    <= '0;
      rx_q    <= '0;
      cca_q   <= '0;
      idle_q  <= '0;
      sleep_q <= '0;
      cons_q  <= '0;
      ev_q    <= '0;
    end else begin
      // Open a new event, or charge one energy to it
      if (cmd_i.clear) begin
        ev_q <= '0;
      end else if (cmd_i.apply) begin
        ev_q <= ev_new;
        unique case (cmd_i.cat)
          CAT_TX:    tx_q    <= acc_new;
          CAT_RX:    rx_q    <= acc_new;
          CAT_CCA:   cca_q   <= acc_new;
          CAT_IDLE:  idle_q  <= acc_new;
          CAT_SLEEP: sleep_q <= acc_new;
          default: begin
          end
        endcase
      end
      // Fold the event into the consumption
      if (cmd_i.consume) begin
        cons_q <= cons_new;
      end
    end
  end

  always_comb begin
    totals_o.remaining = sat_addsub({1'b0, init_i}, cons_q, 1'b1);
    totals_o.event_fj  = ev_q;
    totals_o.tx        = tx_q;
    totals_o.rx        = rx_q;
    totals_o.cca       = cca_q;
    totals_o.idle      = idle_q;
    totals_o.sleep     = sleep_q;
  end

endmodule

@@ rtl/radio_energy_accountant.sv @@
// Radio energy accountant top level: stream ports, configuration registers, event sequencer.
// Each event takes k = 0..3 energy charges, each worked out by the energy unit in NCH
// multiply steps, NCH = ceil(TIME_WIDTH/16), then ND divide-by-1000 digit steps,
// ND = ceil((42 + 16*NCH)/4). One event at a time: the next is accepted in the cycle after
// the result loads, later while one waits.
// Reset (async, active low) clears state, loads defaults. Uses rea_pkg, energy unit, ledger.
module radio_energy_accountant #(
  parameter int unsigned TIME_WIDTH = rea_pkg::TIME_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input events
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // Fields from bit 0: mode[3], now_us[TIME_WIDTH], duration_us[32], zero pad
  input  logic [((rea_pkg::MODE_W + TIME_WIDTH + rea_pkg::DUR_W + 7) / 8) * 8 - 1:0]
                                         s_axis_tdata,
  // Results
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // Fields from bit 0: remaining_fj[64], event_fj[64], tx_total_fj[63], rx_total_fj[64],
  // cca_total_fj[63], idle_total_fj[63], sleep_total_fj[63], asleep[1], zero pad
  output logic [rea_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [rea_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rea_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rea_pkg::*;

  // Configuration registers
  logic [SUP_W-1:0]  supply_q;
  logic [CUR_W-1:0]  tx_cur_q, rx_cur_q, idle_cur_q, sleep_cur_q;
  logic [EMAG_W-1:0] init_q;
  logic [US16_W-1:0] cca_time_q, min_gap_q;

  // Event and time state
  sq_state_e         state_q, state_d;
  logic [1:0]        step_q, step_d;
  logic [MODE_W-1:0] mode_q;
  logic [TIME_WIDTH-1:0] now_q, span_q, last_idle_q, sleep_start_q;
  logic [DUR_W-1:0]  dur_q;
  logic              sleep_flag_q;
  logic              m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  logic              take_in, take_diff, take_span, commit, load_out, eu_start;
  job_t              job;
  ledger_cmd_t       lcmd;
  ledger_totals_t    totals;
  logic [CUR_W-1:0]  eu_cur;
  logic [TIME_WIDTH-1:0] eu_time, span_base, span_extra, span_n;
  logic [TIME_WIDTH:0]   diff_w, sub_w;
  logic              eu_done;
  logic [EMAG_W-1:0] eu_energy;
  logic              is_sleep_mode;

  function automatic job_t mk_job(cur_sel_e cur, time_sel_e tsel, cat_e cat,
                                  logic sub, logic last);
    job_t j;
    j.valid = 1'b1;
    j.cur   = cur;
    j.tsel  = tsel;
    j.cat   = cat;
    j.sub   = sub;
    j.last  = last;
    return j;
  endfunction

  // Charges of each event kind, in the order the event energy is summed
  always_comb begin
    job = '0;
    unique case (mode_e'(mode_q))
      MODE_TX: begin
        unique case (step_q)
          2'd0:    job = mk_job(CUR_TX, TSEL_DUR, CAT_TX, 1'b0, 1'b0);
          2'd1:    job = mk_job(CUR_IDLE, TSEL_SPAN, CAT_IDLE, 1'b0, 1'b0);
          default: job = mk_job(CUR_RX, TSEL_DUR, CAT_RX, 1'b1, 1'b1);
        endcase
      end
      MODE_RX: begin
        if (step_q == 2'd0) begin
          job = mk_job(CUR_RX, TSEL_DUR, CAT_RX, 1'b0, 1'b0);
        end else begin
          job = mk_job(CUR_IDLE, TSEL_SPAN, CAT_IDLE, 1'b0, 1'b1);
        end
      end
      MODE_CCA: begin
        if (step_q == 2'd0) begin
          job = mk_job(CUR_RX, TSEL_CCA, CAT_CCA, 1'b0, 1'b0);
        end else begin
          job = mk_job(CUR_IDLE, TSEL_SPAN, CAT_IDLE, 1'b0, 1'b1);
        end
      end
      MODE_SLEEP_START: job = mk_job(CUR_IDLE, TSEL_SPAN, CAT_IDLE, 1'b0, 1'b1);
      MODE_SLEEP_END:   job = mk_job(CUR_SLEEP, TSEL_SPAN, CAT_SLEEP, 1'b0, 1'b1);
      default:          job = '0;
    endcase
  end

  // Span arithmetic: raw difference first, then duration and gap handling
  always_comb begin
    is_sleep_mode = (mode_q == MODE_SLEEP_START) || (mode_q == MODE_SLEEP_END);
    span_base  = (mode_q == MODE_SLEEP_END) ? sleep_start_q : last_idle_q;
    span_extra = ((mode_q == MODE_TX) || (mode_q == MODE_RX)) ? TIME_WIDTH'(dur_q) : '0;
    diff_w     = {1'b0, now_q} - {1'b0, span_base};
    sub_w      = {1'b0, span_q} - {1'b0, span_extra};
    if (sub_w[TIME_WIDTH] || (sub_w[TIME_WIDTH-1:0] == '0)) begin
      span_n = '0;
    end else begin
      span_n = sub_w[TIME_WIDTH-1:0];
    end
    if (is_sleep_mode && !(span_q > TIME_WIDTH'(min_gap_q))) begin
      span_n = '0;
    end
  end

  // Operand selection for the energy unit
  always_comb begin
    unique case (job.cur)
      CUR_TX:    eu_cur = tx_cur_q;
      CUR_RX:    eu_cur = rx_cur_q;
      CUR_IDLE:  eu_cur = idle_cur_q;
      CUR_SLEEP: eu_cur = sleep_cur_q;
      default:   eu_cur = '0;
    endcase
    unique case (job.tsel)
      TSEL_DUR:  eu_time = TIME_WIDTH'(dur_q);
      TSEL_SPAN: eu_time = span_q;
      TSEL_CCA:  eu_time = TIME_WIDTH'(cca_time_q);
      default:   eu_time = '0;
    endcase
  end

  // Event sequencer
  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    s_axis_tready = (state_q == SQ_IDLE);
    take_in       = 1'b0;
    take_diff     = 1'b0;
    take_span     = 1'b0;
    commit        = 1'b0;
    load_out      = 1'b0;
    eu_start      = 1'b0;
    lcmd          = '0;
    lcmd.cat      = job.cat;
    lcmd.sub      = job.sub;
    unique case (state_q)
      SQ_IDLE: begin
        if (s_axis_tvalid) begin
          take_in    = 1'b1;
          lcmd.clear = 1'b1;
          step_d     = '0;
          state_d    = SQ_DIFF;
        end
      end
      SQ_DIFF: begin
        take_diff = 1'b1;
        state_d   = SQ_SPAN;
      end
      SQ_SPAN: begin
        take_span = 1'b1;
        state_d   = job.valid ? SQ_REQ : SQ_CONSUME;
      end
      SQ_REQ: begin
        eu_start = 1'b1;
        state_d  = SQ_WAIT;
      end
      SQ_WAIT: begin
        if (eu_done) begin
          lcmd.apply = 1'b1;
          if (job.last) begin
            state_d = SQ_CONSUME;
          end else begin
            step_d  = step_q + 2'd1;
            state_d = SQ_REQ;
          end
        end
      end
      SQ_CONSUME: begin
        lcmd.consume = 1'b1;
        commit       = 1'b1;
        state_d      = SQ_OUT;
      end
      SQ_OUT: begin
        // Wait for the output register to free up
        if (!m_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = SQ_IDLE;
        end
      end
      default: begin
        state_d = SQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      supply_q    <= SUPPLY_RST;
      tx_cur_q    <= TX_CUR_RST;
      rx_cur_q    <= RX_CUR_RST;
      idle_cur_q  <= IDLE_CUR_RST;
      sleep_cur_q <= SLEEP_CUR_RST;
      init_q      <= INIT_ENERGY_RST;
      cca_time_q  <= CCA_TIME_RST;
      min_gap_q   <= MIN_GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SUPPLY_MV:   supply_q    <= cfg_data_i[SUP_W-1:0];
        CFG_TX_CUR:      tx_cur_q    <= cfg_data_i[CUR_W-1:0];
        CFG_RX_CUR:      rx_cur_q    <= cfg_data_i[CUR_W-1:0];
        CFG_IDLE_CUR:    idle_cur_q  <= cfg_data_i[CUR_W-1:0];
        CFG_SLEEP_CUR:   sleep_cur_q <= cfg_data_i[CUR_W-1:0];
        CFG_INIT_ENERGY: init_q      <= cfg_data_i;
        CFG_CCA_TIME:    cca_time_q  <= cfg_data_i[US16_W-1:0];
        CFG_MIN_GAP:     min_gap_q   <= cfg_data_i[US16_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Capture the event and work out its span
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      mode_q <= s_axis_tdata[MODE_W-1:0];
      now_q  <= s_axis_tdata[MODE_W +: TIME_WIDTH];
      dur_q  <= s_axis_tdata[MODE_W + TIME_WIDTH +: DUR_W];
    end
    if (take_diff) begin
      span_q <= diff_w[TIME_WIDTH] ? '0 : diff_w[TIME_WIDTH-1:0];
    end else if (take_span) begin
      span_q <= span_n;
    end
  end

  // Advance the time state once the event is booked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idle_q   <= '0;
      sleep_start_q <= '0;
      sleep_flag_q  <= 1'b0;
    end else if (commit) begin
      unique case (mode_e'(mode_q))
        MODE_TX, MODE_RX: begin
          last_idle_q <= now_q;
        end
        MODE_SLEEP_START: begin
          sleep_start_q <= now_q;
          sleep_flag_q  <= 1'b1;
        end
        MODE_SLEEP_END: begin
          last_idle_q  <= now_q;
          sleep_flag_q <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  rea_energy_unit #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_energy (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (eu_start),
    .current_i (eu_cur),
    .supply_i  (supply_q),
    .time_i    (eu_time),
    .done_o    (eu_done),
    .energy_o  (eu_energy)
  );

  rea_ledger u_ledger (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (lcmd),
    .energy_i (eu_energy),
    .init_i   (init_q),
    .totals_o (totals)
  );

  // Output register: hold a result until the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (load_out) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      m_data_q <= OUT_TDATA_W'({sleep_flag_q,
                                totals.sleep[EMAG_W-1:0],
                                totals.idle[EMAG_W-1:0],
                                totals.cca[EMAG_W-1:0],
                                totals.rx,
                                totals.tx[EMAG_W-1:0],
                                totals.event_fj,
                                totals.remaining});
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
